/* src/wvc_pkg.sv */
package wvc_pkg;

    // request codes
    localparam logic [1:0] REQ_VOTE  = 2'd0;
    localparam logic [1:0] REQ_TICK  = 2'd1;
    localparam logic [1:0] REQ_RESET = 2'd2;
    localparam logic [1:0] REQ_SPARE = 2'd3;

    // result status codes
    localparam logic [2:0] ST_COUNTED = 3'd0;
    localparam logic [2:0] ST_REJECT  = 3'd1;
    localparam logic [2:0] ST_DUP     = 3'd2;
    localparam logic [2:0] ST_ALERT   = 3'd3;
    localparam logic [2:0] ST_DONE    = 3'd4;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_VOTES  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 1'd1;

    localparam logic [3:0]  VOTES_RST  = 4'd3;
    localparam logic [15:0] WINDOW_RST = 16'd2000;
    localparam logic [31:0] TICK_GRACE = 32'd100;

    typedef struct packed {
        logic [7:0]  node;
        logic [31:0] vtime;
        logic [15:0] pga;
    } t_slot;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SEQ,
        S_DUP,
        S_STORE,
        S_AISSUE,
        S_ASCAN,
        S_AFLUSH,
        S_RMS,
        S_OUT
    } t_wvc_state;

    typedef enum logic [1:0] {
        RMS_IDLE,
        RMS_DIV,
        RMS_SQRT
    } t_rms_state;

endpackage

/* src/wvc_if.sv */
interface wvc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [31:0] now_ms;
    logic [7:0]  node_id;
    logic [31:0] sequence_req;
    logic [31:0] vote_time;
    logic [15:0] pga;

    modport source (output valid, req_type, now_ms, node_id, sequence_req, vote_time, pga,
                    input ready);
    modport sink   (input valid, req_type, now_ms, node_id, sequence_req, vote_time, pga,
                    output ready);
endinterface

interface wvc_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic        alert;
    logic [3:0]  vote_count;
    logic [15:0] rms_pga;
    logic [31:0] result_time;

    modport source (output valid, status, alert, vote_count, rms_pga, result_time,
                    input ready);
    modport sink   (input valid, status, alert, vote_count, rms_pga, result_time,
                    output ready);
endinterface

interface wvc_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [wvc_pkg::CFG_IDX_W-1:0] index;
    logic [15:0]                   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* src/wvc_rms.sv */
// floor(sqrt(floor(sum / div))): restoring divide, one quotient bit a cycle,
// then a 16-step digit-by-digit square root.
module wvc_rms #(
    parameter int SUM_W = 36,
    parameter int DIV_W = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [SUM_W-1:0] i_sum,
    input  logic [DIV_W-1:0] i_div,
    output logic             o_done,
    output logic [15:0]      o_root
);
    localparam int CNT_W = $clog2(SUM_W + 1);

    wvc_pkg::t_rms_state r_state, n_state;
    logic [SUM_W-1:0] r_dvd, n_dvd;
    logic [DIV_W:0]   r_rem, n_rem;
    logic [DIV_W-1:0] r_div, n_div;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [31:0]      r_rad, n_rad;
    logic [18:0]      r_srem, n_srem;
    logic [15:0]      r_root, n_root;
    logic             r_done, n_done;

    logic [DIV_W:0] s_rem_sh;
    logic [18:0]    s_srem_sh, s_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wvc_pkg::RMS_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_dvd  <= n_dvd;
        r_rem  <= n_rem;
        r_div  <= n_div;
        r_cnt  <= n_cnt;
        r_rad  <= n_rad;
        r_srem <= n_srem;
        r_root <= n_root;
    end

    always_comb begin
        n_state   = r_state;
        n_dvd     = r_dvd;
        n_rem     = r_rem;
        n_div     = r_div;
        n_cnt     = r_cnt;
        n_rad     = r_rad;
        n_srem    = r_srem;
        n_root    = r_root;
        n_done    = 1'b0;
        s_rem_sh  = {r_rem[DIV_W-1:0], r_dvd[SUM_W-1]};
        s_srem_sh = {r_srem[16:0], r_rad[31:30]};
        s_trial   = {1'b0, r_root, 2'b01};
        case (r_state)
            wvc_pkg::RMS_IDLE: begin
                if (i_start) begin
                    n_dvd   = i_sum;
                    n_div   = i_div;
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_state = wvc_pkg::RMS_DIV;
                end
            end
            wvc_pkg::RMS_DIV: begin
                if (s_rem_sh >= {1'b0, r_div}) begin
                    n_rem = s_rem_sh - {1'b0, r_div};
                    n_dvd = {r_dvd[SUM_W-2:0], 1'b1};
                end else begin
                    n_rem = s_rem_sh;
                    n_dvd = {r_dvd[SUM_W-2:0], 1'b0};
                end
                if (r_cnt == CNT_W'(SUM_W - 1)) begin
                    n_rad   = n_dvd[31:0];
                    n_srem  = '0;
                    n_root  = '0;
                    n_cnt   = '0;
                    n_state = wvc_pkg::RMS_SQRT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            wvc_pkg::RMS_SQRT: begin
                n_rad = {r_rad[29:0], 2'b00};
                if (s_srem_sh >= s_trial) begin
                    n_srem = s_srem_sh - s_trial;
                    n_root = {r_root[14:0], 1'b1};
                end else begin
                    n_srem = s_srem_sh;
                    n_root = {r_root[14:0], 1'b0};
                end
                if (r_cnt == CNT_W'(15)) begin
                    n_done  = 1'b1;
                    n_state = wvc_pkg::RMS_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            default: n_state = wvc_pkg::RMS_IDLE;
        endcase
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

/* src/windowed_vote_consensus.sv */
// Windowed vote consensus: collects sensor votes from nodes 1..NODES inside a
// time window, drops unknown nodes, replayed sequence numbers and second votes
// from one node, and raises one alert per window when the vote count reaches
// the quorum register, reporting the floor RMS pga and the latest vote
// timestamp. One word is handled at a time. A tick, reset or unknown-node vote
// is settled at decode; a vote then checks its sequence number, a counted vote
// scans the window's slots for duplicates before it is stored, and a duplicate
// stops the scan at the match, since the per-node sequence memory and the slot
// memory each have one registered read port. An alerting vote then reads every
// stored slot for the sum of squares, runs a bit-serial divide by the count
// (SUM_W = 32 + bits of NODES) and a square root, and waits for the done flag.
// The result sits in an output register, and the next word is taken while it
// waits.
module windowed_vote_consensus #(
    parameter int NODES = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    wvc_in_if.sink           i_req,
    wvc_out_if.source        o_res,
    wvc_cfg_if.sink          i_cfg
);
    localparam int IW    = $clog2(NODES);
    localparam int CW    = $clog2(NODES + 1);
    localparam int MW    = (CW > 4) ? CW : 4;
    localparam int SUM_W = 32 + CW;

    // state memories: last sequence per node, vote slots of the open window
    logic [31:0]    seq_mem  [NODES];
    wvc_pkg::t_slot slot_mem [NODES];

    wvc_pkg::t_wvc_state r_state, n_state;

    // captured word
    logic [1:0]  r_req, n_req;
    logic [31:0] r_now, n_now;
    logic [7:0]  r_node, n_node;
    logic [31:0] r_seq, n_seq;
    logic [31:0] r_vtime, n_vtime;
    logic [15:0] r_pga, n_pga;

    // config
    logic [3:0]  r_vr;
    logic [15:0] r_wms;

    // window state
    logic [CW-1:0] r_count, n_count;
    logic [31:0]   r_wstart, n_wstart;
    logic          r_open, n_open;
    logic          r_fired, n_fired;
    logic [NODES-1:0] r_seen, n_seen;

    // scan / alert datapath
    logic [IW-1:0]    r_scan, n_scan;
    logic [SUM_W-1:0] r_sum, n_sum;
    logic [31:0]      r_sq, n_sq;
    logic             r_sq_v, n_sq_v;
    logic [31:0]      r_tmax, n_tmax;

    // staged result
    logic [2:0]  r_st, n_st;
    logic [15:0] r_npga, n_npga;
    logic [31:0] r_rtime, n_rtime;

    // output register
    logic        r_ov, n_ov;
    logic [2:0]  r_o_st, n_o_st;
    logic        r_o_al, n_o_al;
    logic [3:0]  r_o_cnt, n_o_cnt;
    logic [15:0] r_o_pga, n_o_pga;
    logic [31:0] r_o_time, n_o_time;

    // memory ports
    logic [31:0]    r_seq_rd;
    wvc_pkg::t_slot r_slot_rd;
    logic [IW-1:0]  s_idx, s_slot_raddr, s_slot_waddr;
    logic           s_seq_we, s_slot_we;
    wvc_pkg::t_slot s_slot_wdata;

    logic          s_accept, s_invalid, s_reopen, s_eff_fired, s_last;
    logic [31:0]   s_age;
    logic [CW-1:0] s_eff_cnt, s_new_cnt, s_scan_next;
    logic [MW-1:0] s_cnt_ext;

    logic          rms_start, rms_done;
    logic [15:0]   rms_root;
    logic [SUM_W-1:0] s_rms_sum;

    assign s_accept    = i_req.valid & i_req.ready;
    assign i_req.ready = (r_state == wvc_pkg::S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign s_idx       = IW'(r_node - 8'd1);
    assign s_invalid   = (r_node == 8'd0) || ({1'b0, r_node} > 9'(NODES));
    assign s_age       = r_now - r_wstart;
    assign s_scan_next = CW'(r_scan) + CW'(1);
    assign s_last      = (s_scan_next == r_count);
    assign s_cnt_ext   = MW'(r_count);
    assign s_rms_sum   = r_sum + SUM_W'(r_sq);

    wvc_rms #(
        .SUM_W (SUM_W),
        .DIV_W (CW)
    ) u_rms (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (rms_start),
        .i_sum   (s_rms_sum),
        .i_div   (r_count),
        .o_done  (rms_done),
        .o_root  (rms_root)
    );

    // memories
    always_ff @(posedge i_clk) begin
        if (s_seq_we) begin
            seq_mem[s_idx] <= r_seq;
        end
        r_seq_rd <= seq_mem[s_idx];
    end

    always_ff @(posedge i_clk) begin
        if (s_slot_we) begin
            slot_mem[s_slot_waddr] <= s_slot_wdata;
        end
        r_slot_rd <= slot_mem[s_slot_raddr];
    end

    // config port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vr  <= wvc_pkg::VOTES_RST;
            r_wms <= wvc_pkg::WINDOW_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                wvc_pkg::CFG_VOTES:  r_vr  <= i_cfg.data[3:0];
                wvc_pkg::CFG_WINDOW: r_wms <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= wvc_pkg::S_IDLE;
            r_count  <= '0;
            r_wstart <= '0;
            r_open   <= 1'b0;
            r_fired  <= 1'b0;
            r_seen   <= '0;
            r_ov     <= 1'b0;
            r_sq_v   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_wstart <= n_wstart;
            r_open   <= n_open;
            r_fired  <= n_fired;
            r_seen   <= n_seen;
            r_ov     <= n_ov;
            r_sq_v   <= n_sq_v;
        end
        r_req    <= n_req;
        r_now    <= n_now;
        r_node   <= n_node;
        r_seq    <= n_seq;
        r_vtime  <= n_vtime;
        r_pga    <= n_pga;
        r_scan   <= n_scan;
        r_sum    <= n_sum;
        r_sq     <= n_sq;
        r_tmax   <= n_tmax;
        r_st     <= n_st;
        r_npga   <= n_npga;
        r_rtime  <= n_rtime;
        r_o_st   <= n_o_st;
        r_o_al   <= n_o_al;
        r_o_cnt  <= n_o_cnt;
        r_o_pga  <= n_o_pga;
        r_o_time <= n_o_time;
    end

    always_comb begin
        n_state  = r_state;
        n_req    = r_req;
        n_now    = r_now;
        n_node   = r_node;
        n_seq    = r_seq;
        n_vtime  = r_vtime;
        n_pga    = r_pga;
        n_count  = r_count;
        n_wstart = r_wstart;
        n_open   = r_open;
        n_fired  = r_fired;
        n_seen   = r_seen;
        n_scan   = r_scan;
        n_sum    = r_sum;
        n_sq     = r_sq;
        n_sq_v   = r_sq_v;
        n_tmax   = r_tmax;
        n_st     = r_st;
        n_npga   = r_npga;
        n_rtime  = r_rtime;
        n_o_st   = r_o_st;
        n_o_al   = r_o_al;
        n_o_cnt  = r_o_cnt;
        n_o_pga  = r_o_pga;
        n_o_time = r_o_time;
        n_ov     = r_ov & ~o_res.ready;

        s_seq_we     = 1'b0;
        s_slot_we    = 1'b0;
        s_slot_raddr = IW'(s_scan_next);
        s_slot_waddr = '0;
        s_slot_wdata = '{node: r_node, vtime: r_vtime, pga: r_pga};
        rms_start    = 1'b0;

        s_reopen    = !r_open || (s_age > {16'd0, r_wms});
        s_eff_cnt   = s_reopen ? '0 : r_count;
        s_eff_fired = s_reopen ? 1'b0 : r_fired;
        s_new_cnt   = (s_eff_cnt < CW'(NODES)) ? s_eff_cnt + CW'(1) : s_eff_cnt;

        case (r_state)
            wvc_pkg::S_IDLE: begin
                if (s_accept) begin
                    n_req   = i_req.req_type;
                    n_now   = i_req.now_ms;
                    n_node  = i_req.node_id;
                    n_seq   = i_req.sequence_req;
                    n_vtime = i_req.vote_time;
                    n_pga   = i_req.pga;
                    n_state = wvc_pkg::S_DECODE;
                end
            end
            wvc_pkg::S_DECODE: begin
                n_npga  = '0;
                n_rtime = r_now;
                n_st    = wvc_pkg::ST_DONE;
                n_state = wvc_pkg::S_OUT;
                case (r_req)
                    wvc_pkg::REQ_TICK: begin
                        if (r_open && (s_age > {16'd0, r_wms} + wvc_pkg::TICK_GRACE)) begin
                            n_count = '0;
                            n_open  = 1'b0;
                        end
                    end
                    wvc_pkg::REQ_RESET: begin
                        n_count = '0;
                        n_open  = 1'b0;
                        n_fired = 1'b0;
                    end
                    wvc_pkg::REQ_VOTE: begin
                        // seq memory read of this node issued now
                        if (s_invalid) begin
                            n_st = wvc_pkg::ST_REJECT;
                        end else begin
                            n_state = wvc_pkg::S_SEQ;
                        end
                    end
                    default: ;
                endcase
            end
            wvc_pkg::S_SEQ: begin
                if (r_seen[s_idx] && (r_seq <= r_seq_rd)) begin
                    n_st    = wvc_pkg::ST_REJECT;
                    n_state = wvc_pkg::S_OUT;
                end else begin
                    s_seq_we      = 1'b1;
                    n_seen[s_idx] = 1'b1;
                    if (r_open && (r_count != '0)) begin
                        s_slot_raddr = '0;
                        n_scan       = '0;
                        n_state      = wvc_pkg::S_DUP;
                    end else begin
                        n_state = wvc_pkg::S_STORE;
                    end
                end
            end
            wvc_pkg::S_DUP: begin
                // compare slot r_scan, fetch the next one
                if (r_slot_rd.node == r_node) begin
                    n_st    = wvc_pkg::ST_DUP;
                    n_state = wvc_pkg::S_OUT;
                end else if (s_last) begin
                    n_state = wvc_pkg::S_STORE;
                end else begin
                    n_scan = r_scan + 1'b1;
                end
            end
            wvc_pkg::S_STORE: begin
                if (s_reopen) begin
                    n_wstart = r_now;
                    n_open   = 1'b1;
                end
                if (s_eff_cnt < CW'(NODES)) begin
                    s_slot_we    = 1'b1;
                    s_slot_waddr = IW'(s_eff_cnt);
                end
                n_count = s_new_cnt;
                if ((MW'(s_new_cnt) >= MW'(r_vr)) && !s_eff_fired) begin
                    n_fired = 1'b1;
                    n_state = wvc_pkg::S_AISSUE;
                end else begin
                    n_fired = s_eff_fired;
                    n_st    = wvc_pkg::ST_COUNTED;
                    n_state = wvc_pkg::S_OUT;
                end
            end
            wvc_pkg::S_AISSUE: begin
                // slot write of the previous cycle has landed
                s_slot_raddr = '0;
                n_scan  = '0;
                n_sum   = '0;
                n_tmax  = '0;
                n_sq_v  = 1'b0;
                n_state = wvc_pkg::S_ASCAN;
            end
            wvc_pkg::S_ASCAN: begin
                n_sq   = {16'd0, r_slot_rd.pga} * {16'd0, r_slot_rd.pga};
                n_sq_v = 1'b1;
                if (r_sq_v) begin
                    n_sum = r_sum + SUM_W'(r_sq);
                end
                if (r_slot_rd.vtime > r_tmax) begin
                    n_tmax = r_slot_rd.vtime;
                end
                if (s_last) begin
                    n_state = wvc_pkg::S_AFLUSH;
                end else begin
                    n_scan = r_scan + 1'b1;
                end
            end
            wvc_pkg::S_AFLUSH: begin
                rms_start = 1'b1;
                n_sq_v    = 1'b0;
                n_state   = wvc_pkg::S_RMS;
            end
            wvc_pkg::S_RMS: begin
                if (rms_done) begin
                    n_st    = wvc_pkg::ST_ALERT;
                    n_npga  = rms_root;
                    n_rtime = r_tmax;
                    n_state = wvc_pkg::S_OUT;
                end
            end
            wvc_pkg::S_OUT: begin
                if (!r_ov || o_res.ready) begin
                    n_ov     = 1'b1;
                    n_o_st   = r_st;
                    n_o_al   = (r_st == wvc_pkg::ST_ALERT);
                    n_o_cnt  = s_cnt_ext[3:0];
                    n_o_pga  = r_npga;
                    n_o_time = r_rtime;
                    n_state  = wvc_pkg::S_IDLE;
                end
            end
            default: n_state = wvc_pkg::S_IDLE;
        endcase
    end

    assign o_res.valid       = r_ov;
    assign o_res.status      = r_o_st;
    assign o_res.alert       = r_o_al;
    assign o_res.vote_count  = r_o_cnt;
    assign o_res.rms_pga     = r_o_pga;
    assign o_res.result_time = r_o_time;

`ifndef SYNTHESIS
    a_alert_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.alert == (o_res.status == wvc_pkg::ST_ALERT)))
        else $error("alert flag disagrees with status");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(NODES))
        else $error("vote count beyond slot count");

    a_fired_in_rms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == wvc_pkg::S_RMS) |-> (r_fired && r_open && (r_count != '0)))
        else $error("rms running without a fired open window");

    a_rms_start_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rms_start |=> (r_state == wvc_pkg::S_RMS) && !rms_start)
        else $error("rms start not followed by wait");
`endif

endmodule

/* sim/tb_windowed_vote_consensus.sv */
`timescale 1ns / 1ps

module tb_windowed_vote_consensus;

    localparam int NODES       = 8;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE      = 120;   // margin for the alert path

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] now_ms;
        logic [7:0]  node_id;
        logic [31:0] sequence_req;
        logic [31:0] vote_time;
        logic [15:0] pga;
    } t_vote_word;

    typedef struct packed {
        logic [2:0]  status;
        logic        alert;
        logic [3:0]  vote_count;
        logic [15:0] rms_pga;
        logic [31:0] result_time;
    } t_verdict;

    logic i_clk;
    logic i_rst_n;

    wvc_in_if  req_bus ();
    wvc_out_if res_bus ();
    wvc_cfg_if cfg_bus ();

    windowed_vote_consensus #(.NODES(NODES)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus.sink),
        .o_res   (res_bus.source),
        .i_cfg   (cfg_bus.sink)
    );

    // ---------------------------------------------------------------
    // Shadow copy of the consensus state
    // ---------------------------------------------------------------
    logic [3:0]  need_votes;
    logic [15:0] win_len;
    logic [31:0] node_seq   [NODES];
    logic        node_known [NODES];
    logic [7:0]  held_node  [NODES];
    logic [31:0] held_time  [NODES];
    logic [15:0] held_pga   [NODES];
    int          held_count;
    logic [31:0] win_start;
    logic        win_open;
    logic        alerted;

    t_verdict    pending_verdicts[$];
    int          failures;
    int          cycles;
    logic        calm;              // no idling on either side while set

    // stimulus-side bookkeeping for well-formed traffic
    logic [31:0] wall_ms;
    logic [31:0] seq_hint [NODES + 1];

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [15:0] floor_sqrt(input logic [63:0] v);
        logic [15:0] r;
        logic [31:0] trial;
        r = '0;
        for (int b = 15; b >= 0; b--) begin
            trial = 32'(r | (16'd1 << b));
            if (64'(trial) * 64'(trial) <= v) begin
                r = r | (16'd1 << b);
            end
        end
        return r;
    endfunction

    task automatic drop_window();
        held_count = 0;
        win_open   = 1'b0;
    endtask

    task automatic reopen_window(input logic [31:0] now);
        drop_window();
        win_start = now;
        win_open  = 1'b1;
        alerted   = 1'b0;
    endtask

    // Works out the verdict for one accepted word and advances the shadow state.
    task automatic tally_vote(input t_vote_word w, output t_verdict v);
        int          idx;
        logic [63:0] sq_sum;
        logic [31:0] newest;
        v = '{status: wvc_pkg::ST_DONE, alert: 1'b0, vote_count: 4'(held_count),
              rms_pga: 16'd0, result_time: w.now_ms};
        if (w.req_type == wvc_pkg::REQ_TICK) begin
            if (win_open && (w.now_ms - win_start) > 32'(win_len) + wvc_pkg::TICK_GRACE) begin
                drop_window();
            end
            v.vote_count = 4'(held_count);
            return;
        end
        if (w.req_type == wvc_pkg::REQ_RESET) begin
            drop_window();
            alerted      = 1'b0;
            v.vote_count = 4'(held_count);
            return;
        end
        if (w.req_type != wvc_pkg::REQ_VOTE) return;     // unused code: no state change

        if (w.node_id == 0 || w.node_id > NODES) begin
            v.status = wvc_pkg::ST_REJECT;
            return;
        end
        idx = int'(w.node_id) - 1;
        if (node_known[idx] && w.sequence_req <= node_seq[idx]) begin
            v.status = wvc_pkg::ST_REJECT;
            return;
        end
        node_seq[idx]   = w.sequence_req;
        node_known[idx] = 1'b1;

        // duplicate check sees the window before any expiry
        if (win_open) begin
            for (int i = 0; i < held_count; i++) begin
                if (held_node[i] == w.node_id) begin
                    v.status = wvc_pkg::ST_DUP;
                    return;
                end
            end
        end
        if (!win_open) reopen_window(w.now_ms);
        if ((w.now_ms - win_start) > 32'(win_len)) reopen_window(w.now_ms);

        if (held_count < NODES) begin
            held_node[held_count] = w.node_id;
            held_time[held_count] = w.vote_time;
            held_pga[held_count]  = w.pga;
            held_count++;
        end
        v.vote_count = 4'(held_count);

        if (held_count >= int'(need_votes) && !alerted) begin
            alerted = 1'b1;
            sq_sum  = '0;
            newest  = '0;
            for (int i = 0; i < held_count; i++) begin
                sq_sum += 64'(held_pga[i]) * 64'(held_pga[i]);
                if (held_time[i] > newest) newest = held_time[i];
            end
            v.status      = wvc_pkg::ST_ALERT;
            v.alert       = 1'b1;
            v.rms_pga     = floor_sqrt(sq_sum / 64'(held_count));
            v.result_time = newest;
            return;
        end
        v.status = wvc_pkg::ST_COUNTED;
    endtask

    // ---------------------------------------------------------------
    // Driving
    // ---------------------------------------------------------------
    task automatic maybe_idle_req();
        if (!calm && $urandom_range(99) < 27) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
    endtask

    // Sends one word; valid stays high after acceptance so that back-to-back
    // words need no second assignment in the same step.
    task automatic send_word(input t_vote_word w);
        t_verdict v;
        maybe_idle_req();
        req_bus.valid        <= 1'b1;
        req_bus.req_type     <= w.req_type;
        req_bus.now_ms       <= w.now_ms;
        req_bus.node_id      <= w.node_id;
        req_bus.sequence_req <= w.sequence_req;
        req_bus.vote_time    <= w.vote_time;
        req_bus.pga          <= w.pga;
        do @(posedge i_clk); while (!req_bus.ready);
        tally_vote(w, v);
        pending_verdicts.push_back(v);
    endtask

    task automatic drain();
        req_bus.valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Register write; only called once the block has drained. Valid is left
    // high so that writes can follow each other; the caller drops it.
    task automatic write_reg(input logic [wvc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] data);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        do @(posedge i_clk); while (!cfg_bus.ready);
        if (idx == wvc_pkg::CFG_VOTES) need_votes = data[3:0];
        else win_len = data;
    endtask

    task automatic set_config(input logic [3:0] votes, input logic [15:0] win);
        drain();
        // upper data bits of the votes register are don't-care
        write_reg(wvc_pkg::CFG_VOTES, {12'($urandom), votes});
        write_reg(wvc_pkg::CFG_WINDOW, win);
        cfg_bus.valid <= 1'b0;
    endtask

    function automatic t_vote_word make_word(input logic [1:0] kind, input logic [31:0] now,
                                             input logic [7:0] node, input logic [31:0] seq,
                                             input logic [31:0] vt, input logic [15:0] pga);
        return '{req_type: kind, now_ms: now, node_id: node, sequence_req: seq,
                 vote_time: vt, pga: pga};
    endfunction

    // ---------------------------------------------------------------
    // Result checking
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_bus.ready <= 1'b0;
        end else begin
            res_bus.ready <= calm ? 1'b1 : ($urandom_range(99) >= 27);
        end
    end

    always @(posedge i_clk) begin
        t_verdict want;
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            if (pending_verdicts.size() == 0) begin
                $error("result word with nothing expected");
                failures++;
            end else begin
                want = pending_verdicts.pop_front();
                if (res_bus.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, res_bus.status);
                    failures++;
                end
                if (res_bus.alert !== want.alert) begin
                    $error("alert: expected %0d, got %0d", want.alert, res_bus.alert);
                    failures++;
                end
                if (res_bus.vote_count !== want.vote_count) begin
                    $error("vote_count: expected %0d, got %0d",
                           want.vote_count, res_bus.vote_count);
                    failures++;
                end
                if (res_bus.rms_pga !== want.rms_pga) begin
                    $error("rms_pga: expected %0d, got %0d",
                           want.rms_pga, res_bus.rms_pga);
                    failures++;
                end
                if (res_bus.result_time !== want.result_time) begin
                    $error("result_time: expected %0d, got %0d",
                           want.result_time, res_bus.result_time);
                    failures++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("windowed_vote_consensus regression: fail");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Field extremes, every request code and the corner cases of the window.
    task automatic test_directed();
        send_word(make_word(wvc_pkg::REQ_VOTE, 32'd10, 8'd0, 32'd1, 32'd5, 16'd1));   // node 0
        send_word(make_word(wvc_pkg::REQ_VOTE, 32'd11, 8'd9, 32'd1, 32'd5, 16'd1));   // past NODES
        send_word(make_word(wvc_pkg::REQ_VOTE, 32'd12, 8'd255, '1, '1, '1));
        send_word(make_word(wvc_pkg::REQ_VOTE, 32'd20, 8'd1, 32'd0, 32'd100, 16'hffff));
        send_word(make_word(wvc_pkg::REQ_VOTE, 32'd21, 8'd1, 32'd0, 32'd100, 16'd5)); // replay
        send_word(make_word(wvc_pkg::REQ_VOTE, 32'd22, 8'd1, 32'd7, 32'd100, 16'd5)); // dup
        send_word(make_word(wvc_pkg::REQ_VOTE, 32'd23, 8'd2, 32'd1, '1, 16'hffff));
        send_word(make_word(wvc_pkg::REQ_VOTE, 32'd24, 8'd3, 32'd1, 32'd0, 16'd0));   // alert
        send_word(make_word(wvc_pkg::REQ_VOTE, 32'd25, 8'd4, 32'd1, 32'd9, 16'd3));   // post-fire
        send_word(make_word(wvc_pkg::REQ_SPARE, 32'hdead_beef, 8'hff, '1, '1, '1));
        send_word(make_word(wvc_pkg::REQ_TICK, 32'd2100, 8'd0, '0, '0, '0));         // in grace
        send_word(make_word(wvc_pkg::REQ_TICK, 32'd2121, 8'd0, '0, '0, '0));         // closes
        // dup check happens before expiry: node 5 then stale again
        send_word(make_word(wvc_pkg::REQ_VOTE, 32'd3000, 8'd5, 32'd1, 32'd1, 16'd1));
        send_word(make_word(wvc_pkg::REQ_VOTE, 32'd9000, 8'd5, 32'd2, 32'd1, 16'd1));
        send_word(make_word(wvc_pkg::REQ_VOTE, 32'd9001, 8'd6, 32'd1, 32'd1, 16'd1)); // reopens
        send_word(make_word(wvc_pkg::REQ_RESET, '1, 8'd0, '0, '0, '0));
        // age computed modulo 2^32 across the wrap
        send_word(make_word(wvc_pkg::REQ_VOTE, 32'hffff_fff0, 8'd7, '1, 32'd4, 16'h8000));
        send_word(make_word(wvc_pkg::REQ_VOTE, 32'd5, 8'd8, 32'hffff_fffe, 32'd6, 16'h7fff));
        send_word(make_word(wvc_pkg::REQ_VOTE, 32'd6, 8'd7, 32'd5, 32'd6, 16'h7fff)); // replay
        send_word(make_word(wvc_pkg::REQ_RESET, 32'd7, 8'd0, '0, '0, '0));
    endtask

    // Filling all slots, never-firing and fire-on-first settings.
    task automatic test_config_extremes();
        set_config(4'd8, 16'hffff);
        for (int n = 1; n <= NODES; n++) begin
            seq_hint[n] = seq_hint[n] + 32'd100;
            send_word(make_word(wvc_pkg::REQ_VOTE, 32'd100 + n, 8'(n), seq_hint[n],
                                32'($urandom), 16'($urandom)));
        end
        set_config(4'd15, 16'd0);                     // above NODES: never fires
        send_word(make_word(wvc_pkg::REQ_RESET, 32'd200, 8'd0, '0, '0, '0));
        for (int n = 1; n <= NODES; n++) begin
            seq_hint[n] = seq_hint[n] + 32'd1;
            send_word(make_word(wvc_pkg::REQ_VOTE, 32'd200, 8'(n), seq_hint[n], 32'd1, 16'd1));
        end
        set_config(4'd0, 16'd50);                     // zero: fires on first vote
        seq_hint[1] = seq_hint[1] + 32'd1;
        send_word(make_word(wvc_pkg::REQ_VOTE, 32'd500, 8'd1, seq_hint[1], 32'd3, 16'd77));
        wall_ms = 32'd600;
    endtask

    // Mostly well-formed traffic: advancing time and fresh sequence numbers,
    // with some replays, bad nodes, time jumps, ticks and resets.
    task automatic random_phase(input int count_words);
        t_vote_word w;
        int         pick;
        int         n;
        for (int k = 0; k < count_words; k++) begin
            if (k == count_words / 3) calm = 1'b1;
            if (k == count_words / 2) calm = 1'b0;
            pick = $urandom_range(99);
            if ($urandom_range(49) == 0) wall_ms = $urandom;
            else wall_ms = wall_ms + $urandom_range(win_len < 400 ? 60 : 900);
            w = make_word(wvc_pkg::REQ_VOTE, wall_ms, 8'd0, '0, wall_ms - $urandom_range(200),
                          16'($urandom));
            if ($urandom_range(9) == 0) w.vote_time = $urandom;
            if (pick < 72) begin
                n = $urandom_range(NODES, 1);
                w.node_id = 8'(n);
                if ($urandom_range(9) == 0) begin
                    w.sequence_req = seq_hint[n] - $urandom_range(3);     // replay
                end else if ($urandom_range(29) == 0) begin
                    w.sequence_req = $urandom;
                    seq_hint[n] = (w.sequence_req > seq_hint[n]) ? w.sequence_req
                                                                 : seq_hint[n];
                end else begin
                    seq_hint[n] = seq_hint[n] + $urandom_range(3, 1);
                    w.sequence_req = seq_hint[n];
                end
            end else if (pick < 78) begin
                w.node_id = ($urandom_range(1) == 0) ? 8'd0 : 8'($urandom_range(255, NODES + 1));
                w.sequence_req = $urandom;
            end else if (pick < 92) begin
                w.req_type = wvc_pkg::REQ_TICK;
                w.node_id = 8'($urandom);
            end else if (pick < 97) begin
                w.req_type = wvc_pkg::REQ_RESET;
            end else begin
                w.req_type = wvc_pkg::REQ_SPARE;
                w.node_id = 8'($urandom);
                w.sequence_req = $urandom;
            end
            send_word(w);
        end
    endtask

    task automatic test_random();
        set_config(4'd3, 16'd2000);
        random_phase(300);
        set_config(4'd1, 16'd0);
        random_phase(180);
        set_config(4'd8, 16'hffff);
        random_phase(220);
        set_config(4'd5, 16'd300);
        random_phase(250);
        set_config(4'($urandom_range(9)), 16'($urandom));
        random_phase(180);
    endtask

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        calm          = 1'b0;
        failures      = 0;
        cycles        = 0;
        req_bus.valid = 1'b0;
        req_bus.req_type = '0;
        req_bus.now_ms = '0;
        req_bus.node_id = '0;
        req_bus.sequence_req = '0;
        req_bus.vote_time = '0;
        req_bus.pga = '0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = '0;
        cfg_bus.data  = '0;
        need_votes = wvc_pkg::VOTES_RST;
        win_len    = wvc_pkg::WINDOW_RST;
        for (int i = 0; i < NODES; i++) begin
            node_seq[i]   = '0;
            node_known[i] = 1'b0;
            held_node[i]  = '0;
            held_time[i]  = '0;
            held_pga[i]   = '0;
        end
        for (int i = 0; i <= NODES; i++) seq_hint[i] = 32'd1000;
        held_count = 0;
        win_start  = '0;
        win_open   = 1'b0;
        alerted    = 1'b0;
        wall_ms    = '0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_config_extremes();
        test_random();
        drain();

        if (failures == 0) begin
            $display("windowed_vote_consensus regression: pass");
        end else begin
            $display("windowed_vote_consensus regression: fail");
        end
        $finish;
    end

endmodule
